[rtl/ats_pkg.sv]
// Package for the amount-to-spoken-tokens block: widths, token kinds, status codes,
// slot layout of the token list and the helper functions of the conversion pipeline.
// Depends on nothing; used by amount_to_spoken_tokens_top.
`default_nettype none

package ats_pkg;

  localparam int unsigned AMT_W          = 40;
  localparam int unsigned RUP_W          = 34;
  localparam int unsigned BCD_DIGITS     = 13;
  localparam int unsigned BCD_W          = 4 * BCD_DIGITS;
  localparam int unsigned DD_STAGES      = 8;
  localparam int unsigned DD_STEPS       = AMT_W / DD_STAGES;
  localparam int unsigned NSLOT          = 18;
  localparam int unsigned SLOT_W         = $clog2(NSLOT);
  localparam int unsigned VAL_W          = 7;
  localparam int unsigned OUT_W          = 16;
  localparam int unsigned MAX_TOKENS_DEF = 32;

  localparam logic [RUP_W-1:0] MAX_RUPEES_RST = 34'd999999999;
  // (reset max_rupees + 1) * 100, the smallest amount in paise that is unsupported
  localparam logic [AMT_W:0]   THR_RST        = 41'd100000000000;
  // 100 crore rupees expressed in paise
  localparam logic [AMT_W-1:0] CRORE_LIMIT    = 40'd100000000000;
  localparam logic [AMT_W-1:0] ONE_RUPEE      = 40'd100;

  typedef enum logic [2:0] {
    KIND_NUMBER   = 3'd0,
    KIND_HUNDRED  = 3'd1,
    KIND_THOUSAND = 3'd2,
    KIND_LAKH     = 3'd3,
    KIND_CRORE    = 3'd4,
    KIND_RUPEES   = 3'd5,
    KIND_PAISE    = 3'd6,
    KIND_ONLY     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_INVALID     = 2'd2,
    ST_NOMEM       = 2'd3
  } status_t;

  // Slot positions of the token list, in speaking order.
  localparam int unsigned SL_CR_A   = 0;
  localparam int unsigned SL_CR_B   = 1;
  localparam int unsigned SL_CRORE  = 2;
  localparam int unsigned SL_LK_A   = 3;
  localparam int unsigned SL_LK_B   = 4;
  localparam int unsigned SL_LAKH   = 5;
  localparam int unsigned SL_TH_A   = 6;
  localparam int unsigned SL_TH_B   = 7;
  localparam int unsigned SL_THOU   = 8;
  localparam int unsigned SL_HU_DIG = 9;
  localparam int unsigned SL_HUND   = 10;
  localparam int unsigned SL_HU_A   = 11;
  localparam int unsigned SL_HU_B   = 12;
  localparam int unsigned SL_RUPEES = 13;
  localparam int unsigned SL_PA_A   = 14;
  localparam int unsigned SL_PA_B   = 15;
  localparam int unsigned SL_PAISE  = 16;
  localparam int unsigned SL_ONLY   = 17;

  typedef struct packed {
    status_t                err;
    logic                   zero;
    logic [BCD_W-1:0]       bcd;
    logic [AMT_W-1:0]       bin;
  } conv_t;

  typedef struct packed {
    logic             a_on;
    logic [VAL_W-1:0] a_val;
    logic             b_on;
    logic [3:0]       b_val;
  } grp_t;

  // A few steps of the shift-and-add-3 binary to BCD conversion.
  function automatic conv_t dd_stage(conv_t c);
    conv_t r;
    r = c;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (r.bcd[4*d +: 4] >= 4'd5) begin
          r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
    end
    return r;
  endfunction

  // Tokens for a two-digit value: 0..20 is one number, above that tens then ones.
  function automatic grp_t speak_pair(logic [3:0] t, logic [3:0] o);
    grp_t             g;
    logic             le20;
    logic [VAL_W-1:0] tens;
    tens    = VAL_W'(t) * VAL_W'(10);
    le20    = (t < 4'd2) || ((t == 4'd2) && (o == 4'd0));
    g.a_on  = (t != 4'd0) || (o != 4'd0);
    g.a_val = le20 ? (tens + VAL_W'(o)) : tens;
    g.b_on  = !le20 && (o != 4'd0);
    g.b_val = o;
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/amount_to_spoken_tokens_top.sv]
// Top level of the amount-to-spoken-tokens block: BCD conversion pipeline, token list
// builder, token serialiser and output register. Depends on ats_pkg.
`default_nettype none

// Usage
// The block turns an amount in paise into the words for speaking it in the Indian
// numbering system. An amount enters as one item on the in_ stream; the out_ stream
// then carries its tokens one item each, in speaking order, with tlast on the final
// one. An amount that cannot be spoken ends with a status-only item (token_valid 0).
// The user writes max_rupees through cfg_we/cfg_wdata only while the block is idle;
// the block does not enforce this. On its way to the first token an amount passes
// the input register, eight conversion stages, the list builder, the serialiser and
// the output register. The serialiser gives one result per cycle while the receiver
// is ready, and an amount that speaks as n results (1 to 18) keeps it busy until the
// last is given; later amounts keep moving up the pipeline and are accepted every
// cycle until it fills.
// Reset: rst_n (synchronous, active low) empties every stage and sets max_rupees to
// 999999999. When the receiver holds out_tready low the output item stays put, the
// serialiser waits, and back-pressure climbs stage by stage up to in_tready; nothing
// is dropped or repeated.

module amount_to_spoken_tokens_top #(
  parameter int unsigned MAX_TOKENS = ats_pkg::MAX_TOKENS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ats_pkg::RUP_W-1:0]    cfg_wdata,   // max_rupees
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ats_pkg::AMT_W-1:0]    in_tdata,    // [39:0] amount in paise
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] token_valid, [3:1] token_kind, [10:4] token_value, [12:11] status, [15:13] zero
  output logic [ats_pkg::OUT_W-1:0]    out_tdata,
  output logic                         out_tlast
);
  import ats_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);

  // Configuration. The threshold is the smallest unsupported amount in paise,
  // (max_rupees + 1) * 100, worked out from the written value at the write edge so
  // that the input compare is a plain one and holds for the very next amount.
  logic [AMT_W:0]   thr_r;
  logic [AMT_W:0]   thr_nxt;

  assign thr_nxt = (AMT_W+1)'({cfg_wdata, 6'b0}) + (AMT_W+1)'({cfg_wdata, 5'b0})
                 + (AMT_W+1)'({cfg_wdata, 2'b0}) + (AMT_W+1)'(100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
    end else if (cfg_we) begin
      thr_r <= thr_nxt;
    end
  end

  // Input classification. An amount below one rupee speaks "zero" and is never
  // rejected; otherwise the limit check comes before the crore range check.
  conv_t conv_in;
  logic  in_zero;
  logic  in_unsup;
  logic  in_inval;

  always_comb begin
    in_zero   = in_tdata < ONE_RUPEE;
    in_unsup  = !in_zero && ({1'b0, in_tdata} >= thr_r);
    in_inval  = !in_zero && (in_tdata >= CRORE_LIMIT);
    conv_in.zero = in_zero;
    conv_in.bcd  = '0;
    conv_in.bin  = in_tdata;
    if (in_unsup) begin
      conv_in.err = ST_UNSUPPORTED;
    end else if (in_inval) begin
      conv_in.err = ST_INVALID;
    end else begin
      conv_in.err = ST_OK;
    end
  end

  // Conversion pipeline: stage 0 is the input register, stages 1..DD_STAGES each
  // run DD_STEPS steps of the binary to BCD conversion. Each stage may be loaded
  // when it is empty or when the stage after it is loading too.
  logic [DD_STAGES:0]   vld_r;
  conv_t                conv_r [DD_STAGES+1];
  logic [DD_STAGES+1:0] rdy;
  logic                 desc_vld_r;
  logic                 ser_load;

  always_comb begin
    rdy[DD_STAGES+1] = !desc_vld_r || ser_load;
    for (int k = DD_STAGES; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k <= DD_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      conv_r[0] <= conv_in;
    end
    for (int k = 1; k <= DD_STAGES; k++) begin
      if (rdy[k]) begin
        conv_r[k] <= dd_stage(conv_r[k-1]);
      end
    end
  end

  // Token list builder. Every possible token has a fixed slot; the mask says which
  // slots this amount speaks. Digit 0 is the units of paise, digit 2 units of rupees.
  logic [3:0]       dig [BCD_DIGITS];
  grp_t             g_cr, g_lk, g_th, g_hu, g_pa;
  kind_t            desc_kind_nxt [NSLOT];
  logic [VAL_W-1:0] desc_val_nxt  [NSLOT];
  logic [NSLOT-1:0] desc_mask_nxt;
  kind_t            desc_kind_r   [NSLOT];
  logic [VAL_W-1:0] desc_val_r    [NSLOT];
  logic [NSLOT-1:0] desc_mask_r;
  status_t          desc_err_r;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      dig[i] = conv_r[DD_STAGES].bcd[4*i +: 4];
    end
    g_cr = speak_pair(dig[10], dig[9]);
    g_lk = speak_pair(dig[8], dig[7]);
    g_th = speak_pair(dig[6], dig[5]);
    g_hu = speak_pair(dig[3], dig[2]);
    g_pa = speak_pair(dig[1], dig[0]);

    for (int i = 0; i < NSLOT; i++) begin
      desc_kind_nxt[i] = KIND_NUMBER;
      desc_val_nxt[i]  = '0;
    end

    desc_val_nxt[SL_CR_A]   = g_cr.a_val;
    desc_val_nxt[SL_CR_B]   = VAL_W'(g_cr.b_val);
    desc_kind_nxt[SL_CRORE] = KIND_CRORE;
    desc_val_nxt[SL_LK_A]   = g_lk.a_val;
    desc_val_nxt[SL_LK_B]   = VAL_W'(g_lk.b_val);
    desc_kind_nxt[SL_LAKH]  = KIND_LAKH;
    desc_val_nxt[SL_TH_A]   = g_th.a_val;
    desc_val_nxt[SL_TH_B]   = VAL_W'(g_th.b_val);
    desc_kind_nxt[SL_THOU]  = KIND_THOUSAND;
    desc_val_nxt[SL_HU_DIG] = VAL_W'(dig[4]);
    desc_kind_nxt[SL_HUND]  = KIND_HUNDRED;
    desc_val_nxt[SL_HU_A]   = g_hu.a_val;
    desc_val_nxt[SL_HU_B]   = VAL_W'(g_hu.b_val);
    desc_kind_nxt[SL_RUPEES] = KIND_RUPEES;
    desc_val_nxt[SL_PA_A]   = g_pa.a_val;
    desc_val_nxt[SL_PA_B]   = VAL_W'(g_pa.b_val);
    desc_kind_nxt[SL_PAISE] = KIND_PAISE;
    desc_kind_nxt[SL_ONLY]  = KIND_ONLY;

    desc_mask_nxt            = '0;
    desc_mask_nxt[SL_CR_A]   = g_cr.a_on;
    desc_mask_nxt[SL_CR_B]   = g_cr.b_on;
    desc_mask_nxt[SL_CRORE]  = g_cr.a_on;
    desc_mask_nxt[SL_LK_A]   = g_lk.a_on;
    desc_mask_nxt[SL_LK_B]   = g_lk.b_on;
    desc_mask_nxt[SL_LAKH]   = g_lk.a_on;
    desc_mask_nxt[SL_TH_A]   = g_th.a_on;
    desc_mask_nxt[SL_TH_B]   = g_th.b_on;
    desc_mask_nxt[SL_THOU]   = g_th.a_on;
    desc_mask_nxt[SL_HU_DIG] = dig[4] != 4'd0;
    desc_mask_nxt[SL_HUND]   = dig[4] != 4'd0;
    // Zero rupees speaks a single number 0 in the units slot.
    desc_mask_nxt[SL_HU_A]   = g_hu.a_on || conv_r[DD_STAGES].zero;
    desc_mask_nxt[SL_HU_B]   = g_hu.b_on;
    desc_mask_nxt[SL_RUPEES] = 1'b1;
    desc_mask_nxt[SL_PA_A]   = g_pa.a_on;
    desc_mask_nxt[SL_PA_B]   = g_pa.b_on;
    desc_mask_nxt[SL_PAISE]  = g_pa.a_on;
    desc_mask_nxt[SL_ONLY]   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_vld_r <= 1'b0;
    end else if (rdy[DD_STAGES+1]) begin
      desc_vld_r <= vld_r[DD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[DD_STAGES+1]) begin
      desc_kind_r <= desc_kind_nxt;
      desc_val_r  <= desc_val_nxt;
      desc_mask_r <= desc_mask_nxt;
      desc_err_r  <= conv_r[DD_STAGES].err;
    end
  end

  // Serialiser: walks the mask from the lowest slot, one result per cycle while the
  // output register can take it. A run already in error gives only the status item;
  // a token beyond MAX_TOKENS is replaced by the capacity status item, which ends the run.
  logic             busy_r;
  status_t          ser_err_r;
  logic [NSLOT-1:0] mask_r;
  kind_t            kind_r [NSLOT];
  logic [VAL_W-1:0] val_r  [NSLOT];
  logic [CNT_W-1:0] cnt_r;

  logic [SLOT_W-1:0] pick;
  logic [NSLOT-1:0]  rest;
  logic              cap_hit;
  logic              emit;
  logic              done;
  logic              item_tok;
  kind_t             item_kind;
  logic [VAL_W-1:0]  item_val;
  status_t           item_st;
  logic              out_vld_r;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_last_r;

  always_comb begin
    pick = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = SLOT_W'(i);
      end
    end
    rest    = mask_r & ~(NSLOT'(1) << pick);
    cap_hit = cnt_r == CNT_W'(MAX_TOKENS);

    item_tok  = 1'b0;
    item_kind = KIND_NUMBER;
    item_val  = '0;
    item_st   = ST_OK;
    done      = 1'b1;
    if (ser_err_r != ST_OK) begin
      item_st = ser_err_r;
    end else if (cap_hit) begin
      item_st = ST_NOMEM;
    end else begin
      item_tok  = 1'b1;
      item_kind = kind_r[pick];
      item_val  = val_r[pick];
      done      = rest == '0;
    end
  end

  assign emit     = busy_r && (!out_vld_r || out_tready);
  assign ser_load = desc_vld_r && (!busy_r || (emit && done));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ser_load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (emit) begin
      busy_r <= !done;
      if (item_tok) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_err_r <= desc_err_r;
      mask_r    <= desc_mask_r;
      kind_r    <= desc_kind_r;
      val_r     <= desc_val_r;
    end else if (emit && item_tok) begin
      mask_r <= rest;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {(OUT_W-13)'(0), item_st, item_val, item_kind, item_tok};
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A status-only item always closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r[0]) |-> out_last_r)
    else $error("status item without tlast");

  // A status-only item never reports success.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r[0]) |-> (out_data_r[12:11] != ST_OK))
    else $error("status item with ok status");

  // Among tokens, exactly the ONLY token ends the run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r[0]) |-> (out_last_r == (out_data_r[3:1] == KIND_ONLY)))
    else $error("tlast does not match the ONLY token");

  // A run without a pending error always has a token left to give.
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (ser_err_r == ST_OK)) |-> (mask_r != '0))
    else $error("serialiser busy with an empty token list");

  // The token count never passes the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= CNT_W'(MAX_TOKENS)))
    else $error("token count beyond capacity");

endmodule

`default_nettype wire

[tb/ats_token_checker.sv]
`timescale 1ns / 1ps
// Checker for amount_to_spoken_tokens_top: follows max_rupees writes, works out the
// token run of every accepted amount and compares each result item with it.
// Depends on ats_pkg only; instantiated beside the block by the testbench top.
module ats_token_checker #(
  parameter int unsigned MAX_TOKENS = ats_pkg::MAX_TOKENS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ats_pkg::RUP_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [ats_pkg::AMT_W-1:0] in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [ats_pkg::OUT_W-1:0] out_tdata,
  input  logic                      out_tlast,
  output int unsigned               mismatches,
  output int unsigned               tokens_due
);
  import ats_pkg::*;

  typedef struct {
    logic             tv;
    kind_t            kind;
    logic [VAL_W-1:0] val;
    status_t          st;
    logic             lst;
  } token_t;

  token_t           due_q[$];   // tokens still to arrive, oldest first
  token_t           run_q[$];   // tokens of the amount now being spoken
  status_t          run_err;
  logic [RUP_W-1:0] max_rupees_q = MAX_RUPEES_RST;
  int unsigned      n_bad = 0;

  // The first error of a run is the one reported.
  function automatic void end_run(status_t code);
    if (run_err == ST_OK) begin
      run_err = code;
    end
  endfunction

  function automatic void add_token(kind_t kind, int unsigned val);
    token_t t;
    if (run_err != ST_OK) begin
      return;
    end
    if (run_q.size() >= MAX_TOKENS) begin
      end_run(ST_NOMEM);
      return;
    end
    t.tv   = 1'b1;
    t.kind = kind;
    t.val  = VAL_W'(val);
    t.st   = ST_OK;
    t.lst  = 1'b0;
    run_q.push_back(t);
  endfunction

  function automatic void say_tens(int unsigned v);
    if (v <= 20) begin
      add_token(KIND_NUMBER, v);
    end else begin
      add_token(KIND_NUMBER, (v / 10) * 10);
      if (v % 10 != 0) begin
        add_token(KIND_NUMBER, v % 10);
      end
    end
  endfunction

  function automatic void say_hundreds(int unsigned v);
    if (v / 100 != 0) begin
      add_token(KIND_NUMBER, v / 100);
      add_token(KIND_HUNDRED, 0);
    end
    if (v % 100 != 0) begin
      say_tens(v % 100);
    end
  endfunction

  function automatic void say_group(int unsigned v, kind_t kind);
    if (v != 0) begin
      say_tens(v);
      add_token(kind, 0);
    end
  endfunction

  // Appends the whole run for one amount to the tokens due.
  function automatic void speak_amount(logic [AMT_W-1:0] amount);
    longint unsigned rupees;
    longint unsigned crore;
    longint unsigned rest;
    int unsigned     paise;
    token_t          t;
    run_q.delete();
    run_err = ST_OK;
    rupees  = 64'(amount) / 64'd100;
    paise   = 32'(64'(amount) % 64'd100);
    if (rupees == 0) begin
      add_token(KIND_NUMBER, 0);
    end else if (rupees > 64'(max_rupees_q)) begin
      end_run(ST_UNSUPPORTED);
    end else begin
      crore = rupees / 64'd10000000;
      rest  = rupees % 64'd10000000;
      if (crore > 99) begin
        end_run(ST_INVALID);
      end else begin
        say_group(32'(crore), KIND_CRORE);
        say_group(32'(rest / 64'd100000), KIND_LAKH);
        rest = rest % 64'd100000;
        say_group(32'(rest / 64'd1000), KIND_THOUSAND);
        say_hundreds(32'(rest % 64'd1000));
      end
    end
    add_token(KIND_RUPEES, 0);
    if (paise != 0) begin
      say_tens(paise);
      add_token(KIND_PAISE, 0);
    end
    add_token(KIND_ONLY, 0);
    if (run_err != ST_OK) begin
      t.tv   = 1'b0;
      t.kind = KIND_NUMBER;
      t.val  = '0;
      t.st   = run_err;
      t.lst  = 1'b1;
      run_q.push_back(t);
    end else begin
      run_q[run_q.size() - 1].lst = 1'b1;
    end
    foreach (run_q[i]) begin
      due_q.push_back(run_q[i]);
    end
  endfunction

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      max_rupees_q = MAX_RUPEES_RST;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        max_rupees_q = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch: item %h last %b arrived with no token due", out_tdata, out_tlast);
          end
        end else begin
          want = due_q.pop_front();
          if (out_tdata[0] !== want.tv || out_tdata[3:1] !== want.kind ||
              out_tdata[10:4] !== want.val || out_tdata[12:11] !== want.st ||
              out_tdata[15:13] !== 3'b000 || out_tlast !== want.lst) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("mismatch: expected valid %0b kind %0d value %0d status %0d last %0b",
                       want.tv, want.kind, want.val, want.st, want.lst);
              $display("          got      valid %0b kind %0d value %0d status %0d last %0b pad %0d",
                       out_tdata[0], out_tdata[3:1], out_tdata[10:4], out_tdata[12:11],
                       out_tlast, out_tdata[15:13]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        speak_amount(in_tdata);
      end
    end
    mismatches <= n_bad;
    tokens_due <= due_q.size();
  end

endmodule

[tb/tb_amount_to_spoken_tokens_top.sv]
`timescale 1ns / 1ps
// Testbench top for amount_to_spoken_tokens_top: clock, reset, amounts, max_rupees
// settings and random idling on both channels; ats_token_checker does the checking.
// Depends on ats_pkg, amount_to_spoken_tokens_top and ats_token_checker.
module tb_amount_to_spoken_tokens_top;
  import ats_pkg::*;

  localparam int unsigned TOKEN_CAP   = MAX_TOKENS_DEF;
  // Cycles with no item accepted on either channel before the run is given up.
  // The longest quiet spell of a correct run is reset plus the pipeline latency
  // plus a few idle bursts, so this is far beyond it.
  localparam int unsigned STALL_LIMIT = 5000;
  // Cycles left after the last token has come, to catch anything surplus.
  localparam int unsigned SETTLE      = 40;
  // Largest rupee part that a 40-bit amount in paise can carry.
  localparam logic [RUP_W-1:0] RUPEES_TOP = 34'd10995116277;
  localparam logic [AMT_W-1:0] AMT_TOP    = '1;

  // Directed amounts, spoken with max_rupees at its reset value. They cover zero
  // rupees with and without paise, values up to twenty as one number, tens with
  // and without a ones digit, every group word, the largest accepted amount, the
  // first unsupported one and the amount with every bit set.
  localparam logic [AMT_W-1:0] DIRECTED [20] = '{
    40'd0, 40'd1, 40'd99, 40'd2000, 40'd2100, 40'd3000, 40'd9999, 40'd10000,
    40'd10520, 40'd99999, 40'd100000, 40'd2112345, 40'd10000000, 40'd99999999,
    40'd1000000000, 40'd2000000001, 40'd99999999999, 40'd100000000000,
    40'd100000000099, 40'd1099511627775
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [RUP_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [AMT_W-1:0] in_tdata = '0;    // [39:0] amount in paise
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // [0] token_valid, [3:1] token_kind, [10:4] token_value, [12:11] status, [15:13] zero
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  int unsigned      mismatches;
  int unsigned      tokens_due;
  int unsigned      quiet_cycles = 0;
  // The setting the stimulus aims its boundary amounts at.
  logic [RUP_W-1:0] cur_max = MAX_RUPEES_RST;
  // Set for the last part of the run, where neither side idles.
  bit               steady = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  amount_to_spoken_tokens_top #(
    .MAX_TOKENS (TOKEN_CAP)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ats_token_checker #(
    .MAX_TOKENS (TOKEN_CAP)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .tokens_due (tokens_due)
  );

  // Watchdog: any accepted item on either side restarts the count. A hang, a lost
  // token or a run that never ends all show up here.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: outside the steady part, out_tready drops now and then between stretches
  // of readiness, some of them long, so that stalls land on every token of a run.
  initial begin : receiver
    int unsigned hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!steady && $urandom_range(3, 0) == 0) begin
        out_tready <= 1'b0;
        hold = $urandom_range(7, 1);
      end else begin
        out_tready <= 1'b1;
        hold = ($urandom_range(5, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      end
      repeat (hold) @(negedge clk);
    end
  end

  // Offers one amount, after an idle burst now and then, and returns at the falling
  // edge after the item has been accepted. tvalid stays high when the next amount
  // follows at once.
  task automatic send_amount(logic [AMT_W-1:0] amount);
    if (!steady && $urandom_range(3, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= amount;
    do begin
      @(posedge clk);
    end while (!in_tready);
    @(negedge clk);
  endtask

  // Holds the input back until every token due has arrived. Every amount gives at
  // least one item, so the block is idle once nothing is due.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tokens_due != 0) begin
      @(negedge clk);
    end
  endtask

  // Register writes happen only with the block idle.
  task automatic set_max_rupees(logic [RUP_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_max    = value;
  endtask

  // A group value that is zero a third of the time, so that groups get skipped.
  function automatic int unsigned pick_group(int unsigned top);
    return ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(top, 1);
  endfunction

  // Random amounts. Most are built group by group like real prices, some sit on
  // either side of the current max_rupees, and the rest are small or raw 40-bit noise.
  function automatic logic [AMT_W-1:0] pick_amount(logic [RUP_W-1:0] lim);
    longint unsigned rupees;
    longint unsigned crore;
    longint unsigned amount;
    int unsigned     paise;
    paise = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(99, 0);
    case ($urandom_range(11, 0))
      0: return AMT_W'({$urandom, $urandom});
      1: return AMT_W'($urandom_range(20000, 0));
      2: rupees = 64'(lim);
      3: rupees = 64'(lim) + 64'd1;
      default: begin
        // A crore count above 99 now and then, reported as invalid once max_rupees lets it by.
        crore  = ($urandom_range(11, 0) == 0) ? $urandom_range(1099, 100) : pick_group(99);
        rupees = crore * 64'd10000000 + 64'(pick_group(99)) * 64'd100000 +
                 64'(pick_group(99)) * 64'd1000 + 64'(pick_group(999));
      end
    endcase
    amount = rupees * 64'd100 + 64'(paise);
    if (amount > 64'(AMT_TOP)) begin
      amount = {$urandom, $urandom};
    end
    return AMT_W'(amount);
  endfunction

  task automatic speak_random(int unsigned count);
    repeat (count) begin
      send_amount(pick_amount(cur_max));
    end
  endtask

  function automatic logic [RUP_W-1:0] random_limit();
    return RUP_W'({$urandom, $urandom} % (64'(RUPEES_TOP) + 64'd1));
  endfunction

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed amounts against the reset setting.
    foreach (DIRECTED[i]) begin
      send_amount(DIRECTED[i]);
    end

    // With max_rupees at zero only a zero rupee part can be spoken.
    set_max_rupees('0);
    send_amount(40'd0);
    send_amount(40'd99);
    send_amount(40'd100);
    send_amount(40'd12345);
    send_amount(AMT_TOP);

    // With the widest setting a crore count above 99 gets through the limit check
    // and must be reported as an invalid group instead.
    set_max_rupees(RUPEES_TOP);
    send_amount(40'd99999999999);
    send_amount(40'd100000000000);
    send_amount(40'd1000000000000);
    send_amount(AMT_TOP);
    speak_random(30);

    // Random settings, mostly above a hundred crore rupees.
    set_max_rupees(random_limit());
    speak_random(40);
    set_max_rupees(random_limit());
    speak_random(20);
    // Let the pipeline run dry in the middle of a phase once.
    drain();
    speak_random(20);
    set_max_rupees(random_limit());
    speak_random(40);

    // A small setting, so that the unsupported boundary comes up often.
    set_max_rupees(RUP_W'($urandom_range(2000000, 1)));
    speak_random(25);

    // Back to the reset value, with both sides running flat out.
    set_max_rupees(MAX_RUPEES_RST);
    steady = 1'b1;
    speak_random(30);

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
